// ===== rtl/obm_pkg.sv =====
// Shared types, action codes and helpers for the order book maintainer.
package obm_pkg;

    localparam int ORDER_SLOTS_DEF  = 4096;
    localparam int PRICE_LEVELS_DEF = 1024;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_EXECUTE = 3'd1;
    localparam logic [2:0] ACT_CANCEL  = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_REPLACE = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] order_ref;
        logic [11:0] new_ref;
        logic        side;
        logic [10:0] price;
        logic [31:0] shares;
    } in_t;

    typedef struct packed {
        logic [31:0] removed_shares;
        logic        order_found;
        logic [10:0] bid_price;
        logic [47:0] bid_qty;
        logic [10:0] ask_price;
        logic [47:0] ask_qty;
        logic [47:0] ahead_qty;
    } out_t;

    // Saturating 48-bit add.
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage

// ===== rtl/obm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module obm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/order_book_maintainer_unit.sv =====
// Top level of the order book maintainer: order table, price levels, best quote.
//
// Usage: feed events enter on the item channel (item_valid / item_stall / item),
// one packed beat per event; each event yields exactly one result beat on the
// result channel (result_valid / result_stall / result).
// One event is worked on at a time. S_ORD reads the order entry; an unknown order
// or an ignored action goes to S_DONE. Execute, cancel, delete and replace reduce
// in S_RED; add, and a replace after S_RED, read the level in S_ADDRD and write it
// in S_ADD, which a rejected add skips. S_DONE loads the result and returns to
// S_IDLE, where the next event is taken. When a reduction empties the best level
// of a side, the next best level is searched by reading the level memory one price
// per cycle. A clear event sweeps both memories, one entry per cycle, then reports.
// ORDER_SLOTS is a power of two; a slot is the low bits of its reference.
// Reset: the same sweep runs after reset, item_stall stays high meanwhile.
// Stall: the result register holds a finished beat while result_stall is high;
// the next event is still accepted and worked on, and waits only at the point
// where its own result would be loaded.
module order_book_maintainer_unit #(
    parameter int ORDER_SLOTS  = obm_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = obm_pkg::PRICE_LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  obm_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output obm_pkg::out_t result
);

    localparam int SW    = $clog2(ORDER_SLOTS);
    localparam int PW    = $clog2(PRICE_LEVELS);
    localparam int LW    = $clog2(2 * PRICE_LEVELS);
    localparam int BW    = $clog2(PRICE_LEVELS + 1);
    localparam int LDEP  = 2 * PRICE_LEVELS;
    localparam int CLR_N = (ORDER_SLOTS > LDEP) ? ORDER_SLOTS : LDEP;
    localparam int CW    = $clog2(CLR_N);
    // Order entry layout: {live, side, level, open, ahead mark}
    localparam int OW    = 82 + PW;
    // Level entry layout: {resting, orders, traded}
    localparam int VW    = 109;

    localparam logic [BW-1:0] NO_LEVEL = BW'(PRICE_LEVELS);
    localparam logic [BW-1:0] TOP_LVL  = BW'(PRICE_LEVELS - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ORD, S_RED, S_ADDRD, S_ADD, S_SCAN, S_DONE
    } state_t;

    function automatic logic [LW-1:0] lvl_idx(input logic sd, input logic [BW-1:0] p);
        return sd ? (LW'(PRICE_LEVELS) + LW'(p)) : LW'(p);
    endfunction

    state_t          state_reg, state_next;
    obm_pkg::in_t    item_reg, item_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [OW-1:0]   ord_reg, ord_next;
    logic [LW-1:0]   lidx_reg, lidx_next;
    logic [SW-1:0]   add_slot_reg, add_slot_next;
    logic            add_side_reg, add_side_next;
    logic [31:0]     removed_reg, removed_next;
    logic            found_reg, found_next;
    logic [47:0]     queue_reg, queue_next;
    logic [BW-1:0]   best_bid_reg, best_bid_next;
    logic [BW-1:0]   best_ask_reg, best_ask_next;
    logic [47:0]     bid_qty_reg, bid_qty_next;
    logic [47:0]     ask_qty_reg, ask_qty_next;
    logic [BW-1:0]   scan_ptr_reg, scan_ptr_next;
    logic            scan_side_reg, scan_side_next;
    logic            scan_more_reg, scan_more_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [BW-1:0]   chk_price_reg, chk_price_next;
    logic            repl_reg, repl_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            clr_res_reg, clr_res_next;
    logic            out_valid_reg, out_valid_next;
    obm_pkg::out_t   out_reg, out_next;

    logic            ord_we;
    logic [SW-1:0]   ord_waddr, ord_raddr;
    logic [OW-1:0]   ord_wdata, ord_rdata;
    logic            lvl_we;
    logic [LW-1:0]   lvl_waddr, lvl_raddr;
    logic [VW-1:0]   lvl_wdata, lvl_rdata;

    logic [SW-1:0]   slot_in, new_slot;
    logic            o_live, o_side;
    logic [PW-1:0]   o_level;
    logic [31:0]     o_open;
    logic [47:0]     o_mark;
    logic [47:0]     l_rest, l_trad;
    logic [12:0]     l_cnt;
    logic            l_present;

    // Reduction and add arithmetic
    logic [31:0]     amount, rem, open_new;
    logic [47:0]     rest_new, trad_new, trad_wr, mark_new;
    logic [12:0]     cnt_new;
    logic            freed, emptied;
    logic [BW-1:0]   lvl_price;
    logic            add_reject;

    assign slot_in  = SW'(item.order_ref);
    assign new_slot = SW'(item_reg.new_ref);

    assign o_mark  = ord_reg[47:0];
    assign o_open  = ord_reg[79:48];
    assign o_level = ord_reg[80 +: PW];
    assign o_side  = ord_reg[80 + PW];
    assign o_live  = ord_reg[81 + PW];

    assign l_trad    = lvl_rdata[47:0];
    assign l_cnt     = lvl_rdata[60:48];
    assign l_rest    = lvl_rdata[108:61];
    assign l_present = (l_rest != '0) || (l_cnt != '0);

    assign add_reject = (item_reg.shares == '0) || (32'(item_reg.price) >= 32'(PRICE_LEVELS));

    obm_ram #(.WIDTH(OW), .DEPTH(ORDER_SLOTS)) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    obm_ram #(.WIDTH(VW), .DEPTH(LDEP)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        slot_next      = slot_reg;
        ord_next       = ord_reg;
        lidx_next      = lidx_reg;
        add_slot_next  = add_slot_reg;
        add_side_next  = add_side_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        queue_next     = queue_reg;
        best_bid_next  = best_bid_reg;
        best_ask_next  = best_ask_reg;
        bid_qty_next   = bid_qty_reg;
        ask_qty_next   = ask_qty_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_side_next = scan_side_reg;
        scan_more_next = scan_more_reg;
        chk_valid_next = chk_valid_reg;
        chk_price_next = chk_price_reg;
        repl_next      = repl_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_res_next   = clr_res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        ord_we    = 1'b0;
        ord_waddr = slot_reg;
        ord_wdata = '0;
        ord_raddr = slot_in;
        lvl_we    = 1'b0;
        lvl_waddr = lidx_reg;
        lvl_wdata = '0;
        lvl_raddr = lidx_reg;

        amount    = (item_reg.action == obm_pkg::ACT_DELETE ||
                     item_reg.action == obm_pkg::ACT_REPLACE) ? o_open : item_reg.shares;
        rem       = (amount < o_open) ? amount : o_open;
        open_new  = o_open - rem;
        freed     = (open_new == '0);
        rest_new  = (l_rest >= 48'(rem)) ? (l_rest - 48'(rem)) : '0;
        trad_new  = (item_reg.action == obm_pkg::ACT_EXECUTE) ?
                    obm_pkg::sat_add48(l_trad, 48'(rem)) : l_trad;
        cnt_new   = (freed && l_cnt != '0) ? (l_cnt - 13'd1) : l_cnt;
        emptied   = (rest_new == '0) && (cnt_new == '0);
        // An emptied level drops its traded total
        trad_wr   = emptied ? 48'd0 : trad_new;
        lvl_price = BW'(o_level);
        mark_new  = obm_pkg::sat_add48(l_trad, l_rest);

        // Hand the result beat over
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ord_we        = (32'(clr_cnt_reg) < 32'(ORDER_SLOTS));
                ord_waddr     = clr_cnt_reg[SW-1:0];
                lvl_we        = (32'(clr_cnt_reg) < 32'(LDEP));
                lvl_waddr     = clr_cnt_reg[LW-1:0];
                best_bid_next = NO_LEVEL;
                best_ask_next = NO_LEVEL;
                bid_qty_next  = '0;
                ask_qty_next  = '0;
                if (32'(clr_cnt_reg) == 32'(CLR_N - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_res_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    slot_next  = slot_in;
                    state_next = S_ORD;
                end
            end

            S_ORD:
            begin
                ord_next     = ord_rdata;
                found_next   = 1'b0;
                removed_next = '0;
                queue_next   = '0;
                lvl_raddr    = lvl_idx(ord_rdata[80 + PW], BW'(ord_rdata[80 +: PW]));
                lidx_next    = lvl_raddr;
                case (item_reg.action) inside
                    obm_pkg::ACT_ADD:
                    begin
                        found_next    = ord_rdata[81 + PW];
                        add_slot_next = slot_reg;
                        add_side_next = item_reg.side;
                        state_next    = S_ADDRD;
                    end
                    obm_pkg::ACT_EXECUTE, obm_pkg::ACT_CANCEL,
                    obm_pkg::ACT_DELETE, obm_pkg::ACT_REPLACE:
                    begin
                        found_next = ord_rdata[81 + PW];
                        state_next = ord_rdata[81 + PW] ? S_RED : S_DONE;
                    end
                    obm_pkg::ACT_CLEAR:
                    begin
                        clr_res_next = 1'b1;
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_RED:
            begin
                add_slot_next = new_slot;
                add_side_next = o_side;
                repl_next     = (item_reg.action == obm_pkg::ACT_REPLACE);
                state_next    = repl_next ? S_ADDRD : S_DONE;
                if (l_present)
                begin
                    removed_next = rem;
                    lvl_we       = 1'b1;
                    lvl_wdata    = {rest_new, cnt_new, trad_wr};
                    ord_we       = 1'b1;
                    ord_wdata    = {~freed, freed ? 1'b0 : o_side, o_level, open_new, o_mark};
                    if ((item_reg.action == obm_pkg::ACT_EXECUTE ||
                         item_reg.action == obm_pkg::ACT_CANCEL) && !freed)
                    begin
                        queue_next = (o_mark > trad_wr) ? (o_mark - trad_wr) : '0;
                    end
                    if (!o_side && lvl_price == best_bid_reg)
                    begin
                        if (emptied)
                        begin
                            // Best bid gone: search downward
                            scan_side_next = 1'b0;
                            scan_more_next = (best_bid_reg != '0);
                            scan_ptr_next  = best_bid_reg - BW'(1);
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            bid_qty_next = rest_new;
                        end
                    end
                    if (o_side && lvl_price == best_ask_reg)
                    begin
                        if (emptied)
                        begin
                            // Best ask gone: search upward
                            scan_side_next = 1'b1;
                            scan_more_next = (best_ask_reg != TOP_LVL);
                            scan_ptr_next  = best_ask_reg + BW'(1);
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            ask_qty_next = rest_new;
                        end
                    end
                end
                else if (item_reg.action == obm_pkg::ACT_EXECUTE ||
                         item_reg.action == obm_pkg::ACT_CANCEL)
                begin
                    queue_next = (o_mark > l_trad) ? (o_mark - l_trad) : '0;
                end
            end

            S_ADDRD:
            begin
                lvl_raddr = lvl_idx(add_side_reg, BW'(item_reg.price));
                lidx_next = lvl_raddr;
                if (add_reject)
                begin
                    queue_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                lvl_we    = 1'b1;
                lvl_wdata = {obm_pkg::sat_add48(l_rest, 48'(item_reg.shares)),
                             (l_cnt < obm_pkg::COUNT_MAX) ? (l_cnt + 13'd1) : l_cnt,
                             l_trad};
                ord_we    = 1'b1;
                ord_waddr = add_slot_reg;
                ord_wdata = {1'b1, add_side_reg, item_reg.price[PW-1:0],
                             item_reg.shares, mark_new};
                queue_next = (mark_new > l_trad) ? (mark_new - l_trad) : '0;
                if (!add_side_reg)
                begin
                    if (best_bid_reg == NO_LEVEL || BW'(item_reg.price) >= best_bid_reg)
                    begin
                        best_bid_next = BW'(item_reg.price);
                        bid_qty_next  = lvl_wdata[108:61];
                    end
                end
                else
                begin
                    if (best_ask_reg == NO_LEVEL || BW'(item_reg.price) <= best_ask_reg)
                    begin
                        best_ask_next = BW'(item_reg.price);
                        ask_qty_next  = lvl_wdata[108:61];
                    end
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                lvl_raddr = lvl_idx(scan_side_reg, scan_ptr_reg);
                if (chk_valid_reg && l_present)
                begin
                    if (!scan_side_reg)
                    begin
                        best_bid_next = chk_price_reg;
                        bid_qty_next  = l_rest;
                    end
                    else
                    begin
                        best_ask_next = chk_price_reg;
                        ask_qty_next  = l_rest;
                    end
                    state_next = repl_reg ? S_ADDRD : S_DONE;
                end
                else if (!scan_more_reg)
                begin
                    if (!scan_side_reg)
                    begin
                        best_bid_next = NO_LEVEL;
                        bid_qty_next  = '0;
                    end
                    else
                    begin
                        best_ask_next = NO_LEVEL;
                        ask_qty_next  = '0;
                    end
                    state_next = repl_reg ? S_ADDRD : S_DONE;
                end
                else
                begin
                    // Issue one price per cycle, check it the next
                    chk_valid_next = 1'b1;
                    chk_price_next = scan_ptr_reg;
                    if (!scan_side_reg)
                    begin
                        scan_more_next = (scan_ptr_reg != '0);
                        scan_ptr_next  = scan_ptr_reg - BW'(1);
                    end
                    else
                    begin
                        scan_more_next = (scan_ptr_reg != TOP_LVL);
                        scan_ptr_next  = scan_ptr_reg + BW'(1);
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_next.removed_shares = removed_reg;
                    out_next.order_found    = found_reg;
                    out_next.bid_price      = 11'(best_bid_reg);
                    out_next.bid_qty        = bid_qty_reg;
                    out_next.ask_price      = 11'(best_ask_reg);
                    out_next.ask_qty        = ask_qty_reg;
                    out_next.ahead_qty      = queue_reg;
                    clr_res_next            = 1'b0;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            best_bid_reg  <= NO_LEVEL;
            best_ask_reg  <= NO_LEVEL;
            bid_qty_reg   <= '0;
            ask_qty_reg   <= '0;
            scan_more_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            repl_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
            best_bid_reg  <= best_bid_next;
            best_ask_reg  <= best_ask_next;
            bid_qty_reg   <= bid_qty_next;
            ask_qty_reg   <= ask_qty_next;
            scan_more_reg <= scan_more_next;
            chk_valid_reg <= chk_valid_next;
            repl_reg      <= repl_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        slot_reg      <= slot_next;
        ord_reg       <= ord_next;
        lidx_reg      <= lidx_next;
        add_slot_reg  <= add_slot_next;
        add_side_reg  <= add_side_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
        queue_reg     <= queue_next;
        scan_ptr_reg  <= scan_ptr_next;
        scan_side_reg <= scan_side_next;
        chk_price_reg <= chk_price_next;
        out_reg       <= out_next;
    end

endmodule

// ===== dv/tb_order_book_maintainer_unit.sv =====
// Self-checking testbench for the order book maintainer: directed table, then random feed events.
module tb_order_book_maintainer_unit;

    localparam int NSLOT = obm_pkg::ORDER_SLOTS_DEF;
    localparam int NLVL  = obm_pkg::PRICE_LEVELS_DEF;

    // Action codes the block must ignore.
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam logic [47:0] TOP48       = 48'hFFFF_FFFF_FFFF;
    localparam logic [10:0] NO_LEVEL    = 11'(NLVL);
    localparam int          RAND_EVENTS = 900;
    // A clear sweep, a best-level scan and the long hold-off fit well inside this.
    localparam int          IDLE_LIMIT  = 30000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          DRAIN_WAIT  = 60;

    typedef struct {
        obm_pkg::in_t  ev;
        bit            typed;
        obm_pkg::out_t want;
    } feed_row_t;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    obm_pkg::in_t  item;
    logic          result_valid;
    logic          result_stall;
    obm_pkg::out_t result;

    // Shadow book: order table and price levels (bid p at p, ask p at NLVL+p).
    bit [1:0]  live_side  [NSLOT];
    bit [9:0]  slot_price [NSLOT];
    bit [31:0] slot_open  [NSLOT];
    bit [47:0] slot_mark  [NSLOT];
    bit [47:0] lvl_rest   [2*NLVL];
    bit [12:0] lvl_cnt    [2*NLVL];
    bit [47:0] lvl_trd    [2*NLVL];

    obm_pkg::out_t book_due[$];
    feed_row_t     feed_rows[$];
    int            errors;
    int            checked;
    int            sent;
    int            act_count[8];
    bit            held_off;
    int            idle_cycles;

    order_book_maintainer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TOP48 : s[47:0];
    endfunction

    function automatic int level_of(input int slot);
        return live_side[slot][1] * NLVL + slot_price[slot];
    endfunction

    function automatic bit level_on(input int idx);
        return lvl_rest[idx] != 0 || lvl_cnt[idx] != 0;
    endfunction

    function automatic bit book_add(input int slot, input bit sd, input logic [10:0] px,
                                    input logic [31:0] sh);
        int idx;
        if (sh == 0 || px >= NLVL)
            return 0;
        idx = sd * NLVL + px;
        slot_mark[slot] = add_sat48(lvl_trd[idx], lvl_rest[idx]);
        lvl_rest[idx] = add_sat48(lvl_rest[idx], {16'b0, sh});
        if (lvl_cnt[idx] != obm_pkg::COUNT_MAX)
            lvl_cnt[idx]++;
        live_side[slot] = {sd, 1'b1};
        slot_price[slot] = px[9:0];
        slot_open[slot] = sh;
        return 1;
    endfunction

    function automatic logic [31:0] book_reduce(input int slot, input logic [31:0] amt,
                                                input bit traded);
        int          idx;
        logic [31:0] take;
        idx = level_of(slot);
        if (!level_on(idx))
            return 0;
        take = (amt < slot_open[slot]) ? amt : slot_open[slot];
        slot_open[slot] -= take;
        lvl_rest[idx] = (lvl_rest[idx] >= take) ? lvl_rest[idx] - take : 48'd0;
        if (traded)
            lvl_trd[idx] = add_sat48(lvl_trd[idx], {16'b0, take});
        if (slot_open[slot] == 0)
        begin
            if (lvl_cnt[idx] != 0)
                lvl_cnt[idx]--;
            live_side[slot] = 0;
        end
        if (lvl_rest[idx] == 0 && lvl_cnt[idx] == 0)
            lvl_trd[idx] = 0;
        return take;
    endfunction

    function automatic logic [47:0] queue_of(input int slot);
        logic [47:0] tr;
        if (!live_side[slot][0])
            return 0;
        tr = lvl_trd[level_of(slot)];
        return (slot_mark[slot] > tr) ? slot_mark[slot] - tr : 48'd0;
    endfunction

    // Apply one event to the shadow book and return the beat it should produce.
    function automatic obm_pkg::out_t book_event(input obm_pkg::in_t ev);
        obm_pkg::out_t o;
        int            r;
        int            n;
        int            p;
        bit            live;
        bit            sd;
        o = '0;
        r = ev.order_ref;
        n = ev.new_ref;
        live = live_side[r][0];
        case (ev.action) inside
            obm_pkg::ACT_ADD:
            begin
                o.order_found = live;
                if (book_add(r, ev.side, ev.price, ev.shares))
                    o.ahead_qty = queue_of(r);
            end
            obm_pkg::ACT_EXECUTE, obm_pkg::ACT_CANCEL:
            begin
                if (live)
                begin
                    o.order_found = 1'b1;
                    o.removed_shares = book_reduce(r, ev.shares,
                                                   ev.action == obm_pkg::ACT_EXECUTE);
                    o.ahead_qty = queue_of(r);
                end
            end
            obm_pkg::ACT_DELETE:
            begin
                if (live)
                begin
                    o.order_found = 1'b1;
                    o.removed_shares = book_reduce(r, slot_open[r], 1'b0);
                end
            end
            obm_pkg::ACT_REPLACE:
            begin
                if (live)
                begin
                    sd = live_side[r][1];
                    o.order_found = 1'b1;
                    o.removed_shares = book_reduce(r, slot_open[r], 1'b0);
                    if (book_add(n, sd, ev.price, ev.shares))
                        o.ahead_qty = queue_of(n);
                end
            end
            obm_pkg::ACT_CLEAR:
            begin
                for (p = 0; p < NSLOT; p++)
                    live_side[p] = 0;
                for (p = 0; p < 2 * NLVL; p++)
                begin
                    lvl_rest[p] = 0;
                    lvl_cnt[p] = 0;
                    lvl_trd[p] = 0;
                end
            end
            default: ;
        endcase
        p = NLVL - 1;
        while (p >= 0 && !level_on(p))
            p--;
        o.bid_price = (p < 0) ? NO_LEVEL : 11'(p);
        o.bid_qty = (p < 0) ? 48'd0 : lvl_rest[p];
        p = 0;
        while (p < NLVL && !level_on(NLVL + p))
            p++;
        o.ask_price = 11'(p);
        o.ask_qty = (p < NLVL) ? lvl_rest[NLVL + p] : 48'd0;
        return o;
    endfunction

    function automatic obm_pkg::in_t mk_event(input logic [2:0] act, input int ref_slot,
                                              input int nref, input bit sd, input int px,
                                              input logic [31:0] sh);
        obm_pkg::in_t ev;
        ev.action = act;
        ev.order_ref = 12'(ref_slot);
        ev.new_ref = 12'(nref);
        ev.side = sd;
        ev.price = 11'(px);
        ev.shares = sh;
        return ev;
    endfunction

    function automatic obm_pkg::out_t mk_beat(input logic [31:0] rem, input bit fnd,
                                              input int bp, input logic [47:0] bs,
                                              input int ap, input logic [47:0] asz,
                                              input logic [47:0] qa);
        obm_pkg::out_t o;
        o.removed_shares = rem;
        o.order_found = fnd;
        o.bid_price = 11'(bp);
        o.bid_qty = bs;
        o.ask_price = 11'(ap);
        o.ask_qty = asz;
        o.ahead_qty = qa;
        return o;
    endfunction

    function automatic void add_row(input obm_pkg::in_t ev, input bit typed,
                                    input obm_pkg::out_t want);
        feed_row_t row;
        row.ev = ev;
        row.typed = typed;
        row.want = want;
        feed_rows.push_back(row);
    endfunction

    function automatic int pick_slot();
        return ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, NSLOT - 1))
                                            : int'($urandom_range(0, 47));
    endfunction

    function automatic int pick_price(input bit sd);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 6)
            return NLVL - 1;
        if (r < 10)
            return $urandom_range(0, 2047);
        return sd ? 500 + int'($urandom_range(0, 10)) : 490 + int'($urandom_range(0, 10));
    endfunction

    function automatic logic [31:0] pick_shares();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 32'd0;
        if (r < 8)
            return 32'hFFFF_FFFF;
        if (r < 14)
            return $urandom;
        return $urandom_range(1, 1000);
    endfunction

    // Mostly well-formed events on a small set of slots and clustered prices; some noise.
    function automatic obm_pkg::in_t rand_event();
        int  roll;
        bit  sd;
        roll = $urandom_range(0, 99);
        sd = 1'($urandom_range(0, 1));
        if (roll < 34)
            return mk_event(obm_pkg::ACT_ADD, pick_slot(), pick_slot(), sd, pick_price(sd),
                            pick_shares());
        if (roll < 54)
            return mk_event(obm_pkg::ACT_EXECUTE, pick_slot(), pick_slot(), sd, pick_price(sd),
                            ($urandom_range(0, 9) == 0) ? pick_shares() : $urandom_range(0, 600));
        if (roll < 66)
            return mk_event(obm_pkg::ACT_CANCEL, pick_slot(), pick_slot(), sd, pick_price(sd),
                            ($urandom_range(0, 9) == 0) ? pick_shares() : $urandom_range(0, 600));
        if (roll < 76)
            return mk_event(obm_pkg::ACT_DELETE, pick_slot(), pick_slot(), sd, pick_price(sd),
                            pick_shares());
        if (roll < 88)
            return mk_event(obm_pkg::ACT_REPLACE, pick_slot(), pick_slot(), sd, pick_price(sd),
                            pick_shares());
        if (roll < 90)
            return mk_event(obm_pkg::ACT_CLEAR, pick_slot(), pick_slot(), sd, pick_price(sd),
                            pick_shares());
        if (roll < 94)
            return mk_event(roll[0] ? ACT_SPARE7 : ACT_SPARE6, pick_slot(), pick_slot(), sd,
                            pick_price(sd), pick_shares());
        return mk_event(3'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095), sd,
                        $urandom_range(0, 2047), $urandom);
    endfunction

    // Sender idle gap: quiet phases with none, otherwise mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if ((sent / 120) % 3 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one beat, hold it until accepted, then record what it should produce.
    task automatic offer(input obm_pkg::in_t ev, input int gap, input bit typed,
                         input obm_pkg::out_t want);
        obm_pkg::out_t o;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= ev;
        do
            @(posedge clk);
        while (item_stall);
        o = book_event(ev);
        book_due.push_back(typed ? want : o);
        act_count[ev.action]++;
        sent++;
    endtask

    task automatic field_chk(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: result %0d field %s: expected %0h, got %0h",
                     $time, checked, name, want, got);
        end
    endtask

    // Result side: check each accepted beat against the oldest expectation and
    // drive result_stall with random stretches plus one long hold-off.
    initial
    begin : result_side
        int            stall_left;
        obm_pkg::out_t want;
        stall_left = 0;
        held_off = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (book_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, got %0h", $time, result);
                end
                else
                begin
                    want = book_due.pop_front();
                    field_chk("removed_shares", 64'(want.removed_shares),
                              64'(result.removed_shares));
                    field_chk("order_found", 64'(want.order_found), 64'(result.order_found));
                    field_chk("bid_price", 64'(want.bid_price), 64'(result.bid_price));
                    field_chk("bid_qty", 64'(want.bid_qty), 64'(result.bid_qty));
                    field_chk("ask_price", 64'(want.ask_price), 64'(result.ask_price));
                    field_chk("ask_qty", 64'(want.ask_qty), 64'(result.ask_qty));
                    field_chk("ahead_qty", 64'(want.ahead_qty), 64'(result.ahead_qty));
                end
                checked++;
            end
            if (!held_off && checked == 300)
            begin
                // Hold off long enough that the block fills and stalls its input.
                held_off = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if ((checked / 150) % 3 != 2 && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : feed_side
        int            i;
        obm_pkg::out_t none;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        errors = 0;
        checked = 0;
        sent = 0;
        idle_cycles = 0;
        none = '0;
        for (i = 0; i < 8; i++)
            act_count[i] = 0;

        // Directed table: empty book, rejected adds, extreme prices and sizes,
        // every action, add onto a live slot, not-live references, clear.
        add_row(mk_event(ACT_SPARE6, 0, 0, 0, 0, 0), 1, mk_beat(0, 0, NLVL, 0, NLVL, 0, 0));
        add_row(mk_event(obm_pkg::ACT_ADD, 0, 0, 0, 10, 0), 1,
                mk_beat(0, 0, NLVL, 0, NLVL, 0, 0));
        add_row(mk_event(obm_pkg::ACT_ADD, 0, 0, 0, NLVL, 5), 1,
                mk_beat(0, 0, NLVL, 0, NLVL, 0, 0));
        add_row(mk_event(obm_pkg::ACT_ADD, 1, 0, 0, NLVL - 1, 32'hFFFF_FFFF), 1,
                mk_beat(0, 0, NLVL - 1, 48'hFFFF_FFFF, NLVL, 0, 0));
        add_row(mk_event(obm_pkg::ACT_ADD, 2, 0, 1, 0, 1), 1,
                mk_beat(0, 0, NLVL - 1, 48'hFFFF_FFFF, 0, 1, 0));
        add_row(mk_event(obm_pkg::ACT_ADD, 3, 0, 1, 0, 10), 0, none);
        add_row(mk_event(obm_pkg::ACT_EXECUTE, 2, 0, 0, 0, 5), 0, none);
        add_row(mk_event(obm_pkg::ACT_EXECUTE, 3, 0, 0, 0, 0), 0, none);
        add_row(mk_event(obm_pkg::ACT_CANCEL, 3, 0, 0, 0, 3), 0, none);
        add_row(mk_event(obm_pkg::ACT_ADD, 4, 0, 0, 5, 7), 0, none);
        add_row(mk_event(obm_pkg::ACT_EXECUTE, 1, 0, 0, 0, 32'h1000), 0, none);
        add_row(mk_event(obm_pkg::ACT_REPLACE, 1, 5, 1, 500, 20), 0, none);
        add_row(mk_event(obm_pkg::ACT_REPLACE, 4, 6, 0, NLVL, 20), 0, none);
        add_row(mk_event(obm_pkg::ACT_ADD, 5, 0, 0, 3, 9), 0, none);
        add_row(mk_event(obm_pkg::ACT_DELETE, 5, 0, 0, 0, 0), 0, none);
        add_row(mk_event(obm_pkg::ACT_EXECUTE, 100, 0, 0, 0, 5), 0, none);
        add_row(mk_event(obm_pkg::ACT_CANCEL, 4095, 0, 1, 0, 5), 0, none);
        add_row(mk_event(obm_pkg::ACT_DELETE, 77, 0, 0, 0, 0), 0, none);
        add_row(mk_event(obm_pkg::ACT_REPLACE, 88, 9, 0, 10, 10), 0, none);
        add_row(mk_event(ACT_SPARE7, 4095, 4095, 1, 2047, 32'hFFFF_FFFF), 0, none);
        add_row(mk_event(obm_pkg::ACT_ADD, 4095, 0, 1, NLVL - 1, 32'hFFFF_FFFF), 0, none);
        add_row(mk_event(obm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0), 1,
                mk_beat(0, 0, NLVL, 0, NLVL, 0, 0));
        add_row(mk_event(obm_pkg::ACT_EXECUTE, 4095, 0, 0, 0, 1), 1,
                mk_beat(0, 0, NLVL, 0, NLVL, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (feed_rows[k])
            offer(feed_rows[k].ev, pick_gap(), feed_rows[k].typed, feed_rows[k].want);
        for (i = 0; i < RAND_EVENTS; i++)
            offer(rand_event(), pick_gap(), 0, none);
        item_valid <= 1'b0;

        while (book_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d events (add %0d, execute %0d, cancel %0d, delete %0d,",
                 sent, act_count[obm_pkg::ACT_ADD], act_count[obm_pkg::ACT_EXECUTE],
                 act_count[obm_pkg::ACT_CANCEL], act_count[obm_pkg::ACT_DELETE]);
        $display("  replace %0d, clear %0d, spare %0d), %0d result beats checked",
                 act_count[obm_pkg::ACT_REPLACE], act_count[obm_pkg::ACT_CLEAR],
                 act_count[ACT_SPARE6] + act_count[ACT_SPARE7], checked);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
